FILE: sv/sfr_pkg.sv
// Shared types and constants for the serial frame receiver with additive checksum.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // Field widths fixed by the frame format
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FUNCTION_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT   = 3'd3;

  // Register reset values
  localparam logic [BYTE_W-1:0] FIRST_HEADER_RST   = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RST  = 8'hAF;
  localparam logic [BYTE_W-1:0] FUNCTION_LIMIT_RST = 8'd240;
  localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RST   = 6'd49;

  // Controller states: parse phases, then result emission
  typedef enum logic [3:0] {
    ST_HDR1,
    ST_HDR2,
    ST_FUNC,
    ST_LEN,
    ST_PAY,
    ST_SUM,
    ST_RD,
    ST_OUT,
    ST_FAIL
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic sum_load;    // start running sum with this byte
    logic sum_add;     // add this byte to running sum
    logic func_load;   // capture function byte
    logic len_load;    // capture length byte, load remaining count, clear write slot
    logic pay_write;   // store payload byte
    logic rd_clear;    // restart read pointer
    logic rd_issue;    // read payload store at read pointer
    logic rd_advance;  // step read pointer
    logic fail_sel;    // present checksum-failure result
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hdr1_hit;
    logic hdr2_hit;
    logic func_ok;
    logic len_ok;
    logic rem_zero;
    logic rem_one;
    logic sum_hit;
    logic rd_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/sfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the payload store.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/sfr_ctrl.sv
// Controller state machine: frame parse phases and result emission sequencing.
// Depends on sfr_pkg for the state type and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             out_ready,
  input  wire sfr_pkg::dp_stat_t stat,
  output logic                  in_ready,
  output logic                  out_valid,
  output sfr_pkg::dp_cmd_t      cmd
);

  sfr_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfr_pkg::ST_HDR1;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sfr_pkg::ST_HDR1: begin
        if (in_valid && stat.hdr1_hit) state_nxt = sfr_pkg::ST_HDR2;
      end
      sfr_pkg::ST_HDR2: begin
        if (in_valid) state_nxt = stat.hdr2_hit ? sfr_pkg::ST_FUNC : sfr_pkg::ST_HDR1;
      end
      sfr_pkg::ST_FUNC: begin
        if (in_valid) state_nxt = stat.func_ok ? sfr_pkg::ST_LEN : sfr_pkg::ST_HDR1;
      end
      sfr_pkg::ST_LEN: begin
        if (in_valid) state_nxt = stat.len_ok ? sfr_pkg::ST_PAY : sfr_pkg::ST_HDR1;
      end
      sfr_pkg::ST_PAY: begin
        if (in_valid) begin
          if (stat.rem_zero) state_nxt = sfr_pkg::ST_HDR1;
          else if (stat.rem_one) state_nxt = sfr_pkg::ST_SUM;
        end
      end
      sfr_pkg::ST_SUM: begin
        if (in_valid) state_nxt = stat.sum_hit ? sfr_pkg::ST_RD : sfr_pkg::ST_FAIL;
      end
      sfr_pkg::ST_RD: begin
        state_nxt = sfr_pkg::ST_OUT;
      end
      sfr_pkg::ST_OUT: begin
        if (out_ready) state_nxt = stat.rd_last ? sfr_pkg::ST_HDR1 : sfr_pkg::ST_RD;
      end
      sfr_pkg::ST_FAIL: begin
        if (out_ready) state_nxt = sfr_pkg::ST_HDR1;
      end
      default: state_nxt = sfr_pkg::ST_HDR1;
    endcase
  end

  // Outputs and datapath commands; ready is high in every parse state, so valid alone
  // marks an input beat there, and out_ready alone marks a result beat while offering
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      sfr_pkg::ST_HDR1: begin
        in_ready     = 1'b1;
        cmd.sum_load = in_valid && stat.hdr1_hit;
      end
      sfr_pkg::ST_HDR2: begin
        in_ready    = 1'b1;
        cmd.sum_add = in_valid && stat.hdr2_hit;
      end
      sfr_pkg::ST_FUNC: begin
        in_ready      = 1'b1;
        cmd.sum_add   = in_valid && stat.func_ok;
        cmd.func_load = in_valid && stat.func_ok;
      end
      sfr_pkg::ST_LEN: begin
        in_ready     = 1'b1;
        cmd.sum_add  = in_valid && stat.len_ok;
        cmd.len_load = in_valid && stat.len_ok;
      end
      sfr_pkg::ST_PAY: begin
        in_ready      = 1'b1;
        cmd.sum_add   = in_valid && !stat.rem_zero;
        cmd.pay_write = in_valid && !stat.rem_zero;
      end
      sfr_pkg::ST_SUM: begin
        in_ready     = 1'b1;
        cmd.rd_clear = in_valid && stat.sum_hit;
      end
      sfr_pkg::ST_RD: begin
        cmd.rd_issue = 1'b1;
      end
      sfr_pkg::ST_OUT: begin
        out_valid      = 1'b1;
        cmd.rd_advance = out_ready && !stat.rd_last;
      end
      sfr_pkg::ST_FAIL: begin
        out_valid    = 1'b1;
        cmd.fail_sel = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/sfr_dp.sv
// Datapath: configuration registers, frame counters, running sum, payload store, results.
// Depends on sfr_pkg and sfr_ram.
`timescale 1ns / 1ps
`default_nettype none

module sfr_dp #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_fire,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfr_pkg::BYTE_W-1:0]     cfg_data,
  input  wire logic [sfr_pkg::BYTE_W-1:0]     rx_byte,
  input  wire sfr_pkg::dp_cmd_t               cmd,
  output sfr_pkg::dp_stat_t                   stat,
  output logic                                res_status,
  output logic [sfr_pkg::BYTE_W-1:0]          res_function_code,
  output logic [sfr_pkg::LEN_W-1:0]           res_payload_length,
  output logic [sfr_pkg::LEN_W-1:0]           res_byte_index,
  output logic [sfr_pkg::BYTE_W-1:0]          res_payload_byte,
  output logic                                res_last
);

  localparam int ADDR_W = $clog2(PAYLOAD_DEPTH);
  localparam logic [ADDR_W-1:0] SLOT_MAX = ADDR_W'(PAYLOAD_DEPTH - 1);

  logic [sfr_pkg::BYTE_W-1:0] first_header_r, second_header_r, function_limit_r;
  logic [sfr_pkg::LEN_W-1:0]  length_limit_r;

  logic [sfr_pkg::BYTE_W-1:0] running_sum_r, running_sum_nxt;
  logic [sfr_pkg::BYTE_W-1:0] frame_function_r;
  logic [sfr_pkg::LEN_W-1:0]  frame_length_r;
  logic [sfr_pkg::LEN_W-1:0]  bytes_remaining_r, bytes_remaining_nxt;
  logic [ADDR_W-1:0]          wr_slot_r, wr_slot_nxt;
  logic [sfr_pkg::LEN_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [ADDR_W-1:0]          rd_slot_r, rd_slot_nxt;
  logic [sfr_pkg::BYTE_W-1:0] rd_data;
  logic                       run_last;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_header_r   <= sfr_pkg::FIRST_HEADER_RST;
      second_header_r  <= sfr_pkg::SECOND_HEADER_RST;
      function_limit_r <= sfr_pkg::FUNCTION_LIMIT_RST;
      length_limit_r   <= sfr_pkg::LENGTH_LIMIT_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        sfr_pkg::REG_FIRST_HEADER:   first_header_r   <= cfg_data;
        sfr_pkg::REG_SECOND_HEADER:  second_header_r  <= cfg_data;
        sfr_pkg::REG_FUNCTION_LIMIT: function_limit_r <= cfg_data;
        sfr_pkg::REG_LENGTH_LIMIT:   length_limit_r   <= cfg_data[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte checks for the controller
  assign run_last      = (rd_idx_r + 1'b1) == frame_length_r;
  assign stat.hdr1_hit = rx_byte == first_header_r;
  assign stat.hdr2_hit = rx_byte == second_header_r;
  assign stat.func_ok  = rx_byte <= function_limit_r;
  assign stat.len_ok   = rx_byte <= {2'b00, length_limit_r};
  assign stat.rem_zero = bytes_remaining_r == '0;
  assign stat.rem_one  = bytes_remaining_r == sfr_pkg::LEN_W'(1);
  assign stat.sum_hit  = rx_byte == running_sum_r;
  assign stat.rd_last  = run_last;

  // Next values of sum, counters and pointers
  always_comb begin
    running_sum_nxt     = running_sum_r;
    bytes_remaining_nxt = bytes_remaining_r;
    wr_slot_nxt         = wr_slot_r;
    rd_idx_nxt          = rd_idx_r;
    rd_slot_nxt         = rd_slot_r;
    if (cmd.sum_load) running_sum_nxt = rx_byte;
    if (cmd.sum_add)  running_sum_nxt = running_sum_r + rx_byte;
    if (cmd.len_load) begin
      bytes_remaining_nxt = rx_byte[sfr_pkg::LEN_W-1:0];
      wr_slot_nxt         = '0;
    end
    if (cmd.pay_write) begin
      bytes_remaining_nxt = bytes_remaining_r - 1'b1;
      wr_slot_nxt         = (wr_slot_r == SLOT_MAX) ? '0 : wr_slot_r + 1'b1;
    end
    if (cmd.rd_clear) begin
      rd_idx_nxt  = '0;
      rd_slot_nxt = '0;
    end
    if (cmd.rd_advance) begin
      rd_idx_nxt  = rd_idx_r + 1'b1;
      rd_slot_nxt = (rd_slot_r == SLOT_MAX) ? '0 : rd_slot_r + 1'b1;
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_sum_r     <= '0;
      bytes_remaining_r <= '0;
      wr_slot_r         <= '0;
      rd_idx_r          <= '0;
      rd_slot_r         <= '0;
      frame_function_r  <= '0;
      frame_length_r    <= '0;
    end else begin
      running_sum_r     <= running_sum_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      wr_slot_r         <= wr_slot_nxt;
      rd_idx_r          <= rd_idx_nxt;
      rd_slot_r         <= rd_slot_nxt;
      if (cmd.func_load) frame_function_r <= rx_byte;
      if (cmd.len_load)  frame_length_r   <= rx_byte[sfr_pkg::LEN_W-1:0];
    end
  end

  // Payload store
  sfr_ram #(
    .WIDTH (sfr_pkg::BYTE_W),
    .DEPTH (PAYLOAD_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.pay_write),
    .wr_addr(wr_slot_r),
    .wr_data(rx_byte),
    .rd_en  (cmd.rd_issue),
    .rd_addr(rd_slot_r),
    .rd_data(rd_data)
  );

  // Result fields; a failure result carries zero index and data
  assign res_status         = cmd.fail_sel;
  assign res_function_code  = frame_function_r;
  assign res_payload_length = frame_length_r;
  assign res_byte_index     = cmd.fail_sel ? '0 : rd_idx_r;
  assign res_payload_byte   = cmd.fail_sel ? '0 : rd_data;
  assign res_last           = cmd.fail_sel ? 1'b1 : run_last;

endmodule

`default_nettype wire

FILE: sv/serial_frame_receiver_checksum.sv
// Top level of the serial frame receiver: header, function, length, payload, checksum.
// Joins sfr_ctrl and sfr_dp; depends on sfr_pkg, sfr_ram, sfr_ctrl and sfr_dp.
//
//   Channel | Ports                                   | Beat
//   --------+-----------------------------------------+------------------------------
//   in      | in_valid, in_ready, in_rx_byte          | one received byte
//   out     | out_valid, out_ready, out_status, ...   | one payload byte or failure
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// An input byte is taken whenever in_valid is high in a parse state. After a good checksum,
// each payload result goes through a store read, then output, where it waits for out_ready;
// a failure result is offered straight from the failure state. The input is held off while
// results are emitted. cfg_ready is always high. Reset is synchronous; the payload store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver_checksum #(
  parameter int PAYLOAD_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_status,
  output logic [sfr_pkg::BYTE_W-1:0]         out_function_code,
  output logic [sfr_pkg::LEN_W-1:0]          out_payload_length,
  output logic [sfr_pkg::LEN_W-1:0]          out_byte_index,
  output logic [sfr_pkg::BYTE_W-1:0]         out_payload_byte,
  output logic                               out_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::BYTE_W-1:0]    cfg_data
);

  sfr_pkg::dp_cmd_t  cmd;
  sfr_pkg::dp_stat_t stat;

  // Take register writes at any time
  assign cfg_ready = 1'b1;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  sfr_dp #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_fire          (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .rx_byte           (in_rx_byte),
    .cmd               (cmd),
    .stat              (stat),
    .res_status        (out_status),
    .res_function_code (out_function_code),
    .res_payload_length(out_payload_length),
    .res_byte_index    (out_byte_index),
    .res_payload_byte  (out_payload_byte),
    .res_last          (out_last)
  );

`ifndef SYNTHESIS
  // Input and output never open together
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is offered");

  // Parser resumes right after the final result
  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("parser did not resume after final result");

  // Run continues after a non-final result
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> !in_ready)
    else $error("input reopened in the middle of a run");

  // Failure result is a single final beat with zero index
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_last && out_byte_index == '0))
    else $error("malformed checksum-failure result");

  // Payload index stays inside the frame
  a_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_status) |-> (out_byte_index < out_payload_length))
    else $error("payload index beyond frame length");
`endif

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for serial_frame_receiver_checksum: random and directed byte streams,
// checked beat by beat against an in-bench frame parser. Depends on sfr_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;

  localparam int STORE_DEPTH   = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam logic [sfr_pkg::CFG_IDX_W-1:0] REG_TOP_INDEX = '1;

  // Parser phases of the frame format
  typedef enum logic [2:0] {
    WAIT_HDR1,
    WAIT_HDR2,
    WAIT_FUNC,
    WAIT_LEN,
    TAKE_PAYLOAD,
    WAIT_SUM
  } frame_phase_t;

  typedef struct {
    logic                       status;
    logic [sfr_pkg::BYTE_W-1:0] func_code;
    logic [sfr_pkg::LEN_W-1:0]  length;
    logic [sfr_pkg::LEN_W-1:0]  index;
    logic [sfr_pkg::BYTE_W-1:0] data;
    logic                       last;
  } frame_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [sfr_pkg::BYTE_W-1:0]    in_rx_byte;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_status;
  logic [sfr_pkg::BYTE_W-1:0]    out_function_code;
  logic [sfr_pkg::LEN_W-1:0]     out_payload_length;
  logic [sfr_pkg::LEN_W-1:0]     out_byte_index;
  logic [sfr_pkg::BYTE_W-1:0]    out_payload_byte;
  logic                          out_last;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sfr_pkg::BYTE_W-1:0]    cfg_data;

  // Register copies kept by the parser model
  logic [sfr_pkg::BYTE_W-1:0] hdr1_cfg;
  logic [sfr_pkg::BYTE_W-1:0] hdr2_cfg;
  logic [sfr_pkg::BYTE_W-1:0] func_limit_cfg;
  logic [sfr_pkg::LEN_W-1:0]  len_limit_cfg;

  // Parser model state
  frame_phase_t               phase;
  logic [sfr_pkg::LEN_W-1:0]  left_count;
  logic [sfr_pkg::LEN_W-1:0]  wr_ptr;
  logic [sfr_pkg::LEN_W-1:0]  frame_len;
  logic [sfr_pkg::BYTE_W-1:0] sum_acc;
  logic [sfr_pkg::BYTE_W-1:0] frame_func;
  logic [sfr_pkg::BYTE_W-1:0] store [STORE_DEPTH];

  frame_result_t              pending_results[$];
  frame_result_t              due;
  logic [sfr_pkg::BYTE_W-1:0] tx_payload[$];

  int err_count = 0;
  int bytes_sent;
  int quiet_cycles;
  int sender_gap_pct;
  int receiver_stall_pct;
  int hold_req = 0;
  int hold_seen;
  int hold_left;

  serial_frame_receiver_checksum #(
    .PAYLOAD_DEPTH(STORE_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_function_code (out_function_code),
    .out_payload_length(out_payload_length),
    .out_byte_index    (out_byte_index),
    .out_payload_byte  (out_payload_byte),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Low byte of a count
  function automatic logic [sfr_pkg::BYTE_W-1:0] to_byte(input int unsigned v);
    return v[sfr_pkg::BYTE_W-1:0];
  endfunction

  // Random byte between two bounds, in either order
  function automatic logic [sfr_pkg::BYTE_W-1:0] rand_byte(input int unsigned lo,
                                                           input int unsigned hi);
    int unsigned v;
    v = $urandom_range(hi, lo);
    return v[sfr_pkg::BYTE_W-1:0];
  endfunction

  // Advance the parser model by one received byte and queue the beats it causes
  function automatic void deframe_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
    frame_result_t r;
    int k;
    if (phase == WAIT_HDR1 && b == hdr1_cfg) begin
      phase = WAIT_HDR2;
      sum_acc = b;
    end else if (phase == WAIT_HDR2 && b == hdr2_cfg) begin
      phase = WAIT_FUNC;
      sum_acc += b;
    end else if (phase == WAIT_FUNC && b <= func_limit_cfg) begin
      phase = WAIT_LEN;
      frame_func = b;
      sum_acc += b;
    end else if (phase == WAIT_LEN && b <= {2'b00, len_limit_cfg}) begin
      phase = TAKE_PAYLOAD;
      frame_len = b[sfr_pkg::LEN_W-1:0];
      left_count = b[sfr_pkg::LEN_W-1:0];
      wr_ptr = '0;
      sum_acc += b;
    end else if (phase == TAKE_PAYLOAD && left_count != 0) begin
      store[wr_ptr] = b;
      wr_ptr++;
      sum_acc += b;
      left_count--;
      if (left_count == 0) phase = WAIT_SUM;
    end else if (phase == WAIT_SUM) begin
      phase = WAIT_HDR1;
      r.func_code = frame_func;
      r.length = frame_len;
      if (sum_acc == b) begin
        for (k = 0; k < frame_len; k++) begin
          r.status = 1'b0;
          r.index = k[sfr_pkg::LEN_W-1:0];
          r.data = store[k];
          r.last = (k == frame_len - 1);
          pending_results.push_back(r);
        end
      end else begin
        r.status = 1'b1;
        r.index = '0;
        r.data = '0;
        r.last = 1'b1;
        pending_results.push_back(r);
      end
    end else begin
      // zero-length frames and rejected bytes drop back to idle unexamined
      phase = WAIT_HDR1;
    end
  endfunction

  // Offer one byte, hold it until the input beat is taken, then update the model
  task automatic send_byte(input logic [sfr_pkg::BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Send a complete frame around tx_payload; sum_skew nonzero corrupts the checksum
  task automatic send_frame(input logic [sfr_pkg::BYTE_W-1:0] func,
                            input logic [sfr_pkg::BYTE_W-1:0] sum_skew);
    logic [sfr_pkg::BYTE_W-1:0] sum;
    logic [sfr_pkg::BYTE_W-1:0] len;
    int i;
    len = to_byte(tx_payload.size());
    sum = hdr1_cfg + hdr2_cfg + func + len;
    send_byte(hdr1_cfg);
    send_byte(hdr2_cfg);
    send_byte(func);
    send_byte(len);
    for (i = 0; i < tx_payload.size(); i++) begin
      sum += tx_payload[i];
      send_byte(tx_payload[i]);
    end
    send_byte(sum + sum_skew);
    tx_payload.delete();
  endtask

  task automatic fill_payload(input int n);
    repeat (n) tx_payload.push_back(rand_byte(0, 255));
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise
  task automatic send_random_frame();
    int kind;
    int cap;
    logic [sfr_pkg::BYTE_W-1:0] func;
    kind = $urandom_range(0, 99);
    func = rand_byte(0, func_limit_cfg);
    cap = (len_limit_cfg < 6'd8) ? int'(len_limit_cfg) : 8;
    if (kind < 70) begin
      if (len_limit_cfg != 0) begin
        if ($urandom_range(0, 4) != 0) fill_payload($urandom_range(1, cap));
        else fill_payload($urandom_range(1, len_limit_cfg));
      end
      send_frame(func, ($urandom_range(0, 6) == 0) ? rand_byte(1, 255) : 8'h00);
    end else if (kind < 78) begin
      send_frame(func, rand_byte(0, 255));
    end else if (kind < 88) begin
      send_byte(hdr1_cfg);
      case ($urandom_range(0, 3))
        0: send_byte(rand_byte(0, 255));
        1: begin
          send_byte(hdr2_cfg);
          send_byte(rand_byte(func_limit_cfg, 255));
        end
        2: begin
          send_byte(hdr2_cfg);
          send_byte(func);
          send_byte(rand_byte(len_limit_cfg, 255));
        end
        default: begin
          send_byte(hdr1_cfg);
          send_byte(hdr2_cfg);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(rand_byte(0, 255));
    end
  endtask

  task automatic send_random_stream(input int count);
    int stop;
    stop = bytes_sent + count;
    while (bytes_sent < stop) send_random_frame();
  endtask

  // Drop valid, wait for every expected beat, then let the block settle
  task automatic wait_drained(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfr_pkg::BYTE_W-1:0] data);
    wait_drained(SETTLE_CYCLES);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sfr_pkg::REG_FIRST_HEADER:   hdr1_cfg = data;
      sfr_pkg::REG_SECOND_HEADER:  hdr2_cfg = data;
      sfr_pkg::REG_FUNCTION_LIMIT: func_limit_cfg = data;
      sfr_pkg::REG_LENGTH_LIMIT:   len_limit_cfg = data[sfr_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all_regs(input logic [sfr_pkg::BYTE_W-1:0] h1,
                                input logic [sfr_pkg::BYTE_W-1:0] h2,
                                input logic [sfr_pkg::BYTE_W-1:0] flim,
                                input logic [sfr_pkg::BYTE_W-1:0] llim);
    write_reg(sfr_pkg::REG_FIRST_HEADER, h1);
    write_reg(sfr_pkg::REG_SECOND_HEADER, h2);
    write_reg(sfr_pkg::REG_FUNCTION_LIMIT, flim);
    write_reg(sfr_pkg::REG_LENGTH_LIMIT, llim);
  endtask

  // Reset config: good frame at the function limit, bad checksum, zero length, rejects
  task automatic test_directed_frames();
    tx_payload.push_back(8'h00);
    tx_payload.push_back(8'hFF);
    send_frame(sfr_pkg::FUNCTION_LIMIT_RST, 8'h00);
    tx_payload.push_back(8'h5A);
    send_frame(8'h00, 8'h33);
    send_frame(8'h01, 8'h00);
    // repeated first header is rejected and not taken as a new start
    send_byte(sfr_pkg::FIRST_HEADER_RST);
    send_byte(sfr_pkg::FIRST_HEADER_RST);
    send_byte(sfr_pkg::SECOND_HEADER_RST);
    // function one above its limit
    send_byte(sfr_pkg::FIRST_HEADER_RST);
    send_byte(sfr_pkg::SECOND_HEADER_RST);
    send_byte(sfr_pkg::FUNCTION_LIMIT_RST + 8'd1);
    // length one above its limit
    send_byte(sfr_pkg::FIRST_HEADER_RST);
    send_byte(sfr_pkg::SECOND_HEADER_RST);
    send_byte(8'h00);
    send_byte({2'b00, sfr_pkg::LENGTH_LIMIT_RST} + 8'd1);
  endtask

  task automatic test_reset_config_random();
    send_random_stream(50);
  endtask

  // Widest limits; the length write carries upper bits that must be masked off
  task automatic test_open_limits();
    write_all_regs(8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_random_stream(30);
  endtask

  // Hold the receiver off through a largest frame while the sender keeps offering
  task automatic test_receiver_hold_off();
    fill_payload(int'(len_limit_cfg));
    hold_req++;
    send_frame(rand_byte(0, func_limit_cfg), 8'h00);
    repeat (2) send_random_frame();
  endtask

  task automatic test_tight_limits();
    write_all_regs(8'hFF, 8'h00, 8'h00, 8'h01);
    send_random_stream(30);
  endtask

  // Indexes past the register list must change nothing
  task automatic test_unmapped_writes();
    logic [sfr_pkg::CFG_IDX_W-1:0] idx;
    idx = sfr_pkg::REG_LENGTH_LIMIT;
    do begin
      idx = idx + 1'b1;
      write_reg(idx, rand_byte(0, 255));
    end while (idx != REG_TOP_INDEX);
    send_random_stream(15);
  endtask

  // Length limit masked to zero: only zero-length frames pass, and they are dropped
  task automatic test_zero_length_limit();
    write_all_regs(8'h55, 8'h55, 8'h80, 8'h40);
    send_random_stream(20);
  endtask

  task automatic test_restored_defaults();
    write_all_regs(sfr_pkg::FIRST_HEADER_RST, sfr_pkg::SECOND_HEADER_RST,
                   sfr_pkg::FUNCTION_LIMIT_RST, {2'b00, sfr_pkg::LENGTH_LIMIT_RST});
    send_random_stream(50);
  endtask

  // Result side: stall at random, or hold off for a long stretch on request
  initial begin
    out_ready <= 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
    end
  end

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      err_count++;
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d, function %0d, index %0d",
               out_status, out_function_code, out_byte_index);
        err_count++;
      end else begin
        due = pending_results.pop_front();
        check_field("status", int'(due.status), int'(out_status));
        check_field("function_code", int'(due.func_code), int'(out_function_code));
        check_field("payload_length", int'(due.length), int'(out_payload_length));
        check_field("byte_index", int'(due.index), int'(out_byte_index));
        check_field("payload_byte", int'(due.data), int'(out_payload_byte));
        check_field("last", int'(due.last), int'(out_last));
      end
    end
  end

  // Count cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("serial_frame_receiver_checksum regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    bytes_sent = 0;
    hdr1_cfg = sfr_pkg::FIRST_HEADER_RST;
    hdr2_cfg = sfr_pkg::SECOND_HEADER_RST;
    func_limit_cfg = sfr_pkg::FUNCTION_LIMIT_RST;
    len_limit_cfg = sfr_pkg::LENGTH_LIMIT_RST;
    phase = WAIT_HDR1;
    left_count = '0;
    wr_ptr = '0;
    frame_len = '0;
    sum_acc = '0;
    frame_func = '0;
    sender_gap_pct = 24;
    receiver_stall_pct = 78;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_reset_config_random();
    test_open_limits();
    test_receiver_hold_off();

    sender_gap_pct = 78;
    receiver_stall_pct = 24;
    test_tight_limits();
    test_unmapped_writes();
    test_zero_length_limit();

    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    test_restored_defaults();

    wait_drained(DRAIN_CYCLES);
    if (err_count == 0) begin
      $display("serial_frame_receiver_checksum regression: pass");
    end else begin
      $display("serial_frame_receiver_checksum regression: fail");
    end
    $finish;
  end

endmodule
